>>> hdl/owbm_pkg.sv
`default_nettype none

package owbm_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam logic [9:0] READ_RECOVERY_TIME = 10'd53;

  localparam int NUM_REGS = 8;
  localparam int ADDR_W = 5;

  localparam logic [9:0] RESET_LOW_DEF     = 10'd480;
  localparam logic [9:0] RESET_RELEASE_DEF = 10'd410;
  localparam logic [9:0] ONE_LOW_DEF       = 10'd10;
  localparam logic [9:0] ONE_HIGH_DEF      = 10'd55;
  localparam logic [9:0] ZERO_LOW_DEF      = 10'd65;
  localparam logic [9:0] ZERO_HIGH_DEF     = 10'd5;
  localparam logic [9:0] READ_LOW_DEF      = 10'd3;
  localparam logic [9:0] READ_SAMPLE_DEF   = 10'd10;

  typedef enum logic [2:0] {
    REG_RESET_LOW     = 3'd0,
    REG_RESET_RELEASE = 3'd1,
    REG_ONE_LOW       = 3'd2,
    REG_ONE_HIGH      = 3'd3,
    REG_ZERO_LOW      = 3'd4,
    REG_ZERO_HIGH     = 3'd5,
    REG_READ_LOW      = 3'd6,
    REG_READ_SAMPLE   = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_RESET = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [5:0] {
    PH_IDLE     = 6'b000001,
    PH_WAITHIGH = 6'b000010,
    PH_LOW      = 6'b000100,
    PH_HIGH     = 6'b001000,
    PH_SAMPLE   = 6'b010000,
    PH_RECOVER  = 6'b100000
  } phase_t;

  typedef struct packed {
    logic [9:0] reset_low_time;
    logic [9:0] reset_release_time;
    logic [9:0] one_low_time;
    logic [9:0] one_high_time;
    logic [9:0] zero_low_time;
    logic [9:0] zero_high_time;
    logic [9:0] read_low_time;
    logic [9:0] read_sample_delay;
  } cfg_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] tx_byte;
    logic       line_in;
  } item_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
  } res_t;

  function automatic logic [9:0] dur_of(input logic [9:0] v);
    return (v == 10'd0) ? 10'd1 : v;
  endfunction

endpackage

`default_nettype wire

>>> hdl/one_wire_byte_master_core.sv
// Single-wire bus master, one request per microsecond tick. Every accepted request
// yields exactly one result: the drive level for that tick, busy, a done pulse and,
// at the end of a byte read, the received byte. Throughput is one request per clock
// cycle while out_stall is low; each request goes from an input register through the
// timing state machine into a result register. out_stall holds the result register and
// backs up into in_stall. Bus timings are set through eight 10-bit registers at byte
// addresses 0x00 to 0x1C; write them only while no operation is running.
`default_nettype none

module one_wire_byte_master_core #(
  parameter logic [9:0] READ_RECOVERY_TIME = owbm_pkg::READ_RECOVERY_TIME,
  parameter int         BITS_PER_BYTE      = owbm_pkg::BITS_PER_BYTE
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_req_type,
  input  wire logic [7:0]                  in_tx_byte,
  input  wire logic                        in_line_in,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_drive_low,
  output logic                             out_busy_res,
  output logic                             out_done_res,
  output logic [7:0]                       out_rx_byte,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [owbm_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  owbm_pkg::cfg_t  cfg;
  owbm_pkg::item_t item_r;
  owbm_pkg::res_t  res;
  owbm_pkg::res_t  res_r;
  logic            in_vld_r;
  logic            out_vld_r;
  logic            advance;
  logic            step;

  assign advance  = !out_vld_r || !out_stall;
  assign step     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;

  owbm_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  owbm_fsm #(
    .READ_RECOVERY_TIME (READ_RECOVERY_TIME),
    .BITS_PER_BYTE      (BITS_PER_BYTE)
  ) u_fsm (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r.req_type <= in_req_type;
      item_r.tx_byte  <= in_tx_byte;
      item_r.line_in  <= in_line_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_drive_low = res_r.drive_low;
  assign out_busy_res  = res_r.busy_res;
  assign out_done_res  = res_r.done_res;
  assign out_rx_byte   = res_r.rx_byte;

endmodule

`default_nettype wire

>>> hdl/owbm_cfg.sv
`default_nettype none

module owbm_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [owbm_pkg::ADDR_W-1:0] cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready,
  output owbm_pkg::cfg_t                   cfg
);

  owbm_pkg::cfg_t     cfg_r;
  owbm_pkg::reg_idx_t idx;
  logic               wr_en;
  logic [9:0]         wdata;
  logic [9:0]         rdata;

  assign cfg_pready = 1'b1;
  assign idx        = owbm_pkg::reg_idx_t'(cfg_paddr[owbm_pkg::ADDR_W-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign wdata      = cfg_pwdata[9:0];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_time     <= owbm_pkg::RESET_LOW_DEF;
      cfg_r.reset_release_time <= owbm_pkg::RESET_RELEASE_DEF;
      cfg_r.one_low_time       <= owbm_pkg::ONE_LOW_DEF;
      cfg_r.one_high_time      <= owbm_pkg::ONE_HIGH_DEF;
      cfg_r.zero_low_time      <= owbm_pkg::ZERO_LOW_DEF;
      cfg_r.zero_high_time     <= owbm_pkg::ZERO_HIGH_DEF;
      cfg_r.read_low_time      <= owbm_pkg::READ_LOW_DEF;
      cfg_r.read_sample_delay  <= owbm_pkg::READ_SAMPLE_DEF;
    end else if (wr_en) begin
      case (idx)
        owbm_pkg::REG_RESET_LOW:     cfg_r.reset_low_time     <= wdata;
        owbm_pkg::REG_RESET_RELEASE: cfg_r.reset_release_time <= wdata;
        owbm_pkg::REG_ONE_LOW:       cfg_r.one_low_time       <= wdata;
        owbm_pkg::REG_ONE_HIGH:      cfg_r.one_high_time      <= wdata;
        owbm_pkg::REG_ZERO_LOW:      cfg_r.zero_low_time      <= wdata;
        owbm_pkg::REG_ZERO_HIGH:     cfg_r.zero_high_time     <= wdata;
        owbm_pkg::REG_READ_LOW:      cfg_r.read_low_time      <= wdata;
        owbm_pkg::REG_READ_SAMPLE:   cfg_r.read_sample_delay  <= wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      owbm_pkg::REG_RESET_LOW:     rdata = cfg_r.reset_low_time;
      owbm_pkg::REG_RESET_RELEASE: rdata = cfg_r.reset_release_time;
      owbm_pkg::REG_ONE_LOW:       rdata = cfg_r.one_low_time;
      owbm_pkg::REG_ONE_HIGH:      rdata = cfg_r.one_high_time;
      owbm_pkg::REG_ZERO_LOW:      rdata = cfg_r.zero_low_time;
      owbm_pkg::REG_ZERO_HIGH:     rdata = cfg_r.zero_high_time;
      owbm_pkg::REG_READ_LOW:      rdata = cfg_r.read_low_time;
      owbm_pkg::REG_READ_SAMPLE:   rdata = cfg_r.read_sample_delay;
      default:                     rdata = 10'd0;
    endcase
  end

  assign cfg_prdata = {22'd0, rdata};

endmodule

`default_nettype wire

>>> hdl/owbm_fsm.sv
`default_nettype none

module owbm_fsm #(
  parameter logic [9:0] READ_RECOVERY_TIME = owbm_pkg::READ_RECOVERY_TIME,
  parameter int         BITS_PER_BYTE      = owbm_pkg::BITS_PER_BYTE
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            step,
  input  wire owbm_pkg::item_t item,
  input  wire owbm_pkg::cfg_t  cfg,
  output owbm_pkg::res_t       res
);

  localparam logic [3:0] BIT_LIMIT = 4'(BITS_PER_BYTE);

  owbm_pkg::phase_t phase_r, phase_nxt;
  owbm_pkg::op_t    op_r, op_nxt;
  logic [9:0]       tc_r, tc_nxt;
  logic [2:0]       bi_r, bi_nxt;
  logic [7:0]       sb_r, sb_nxt;

  always_comb begin
    owbm_pkg::op_t req;
    logic          cur;
    logic          done;
    logic          drive;
    logic [9:0]    dur;
    logic [9:0]    tc_inc;
    logic [3:0]    nb;

    req       = owbm_pkg::op_t'(item.req_type);
    phase_nxt = phase_r;
    op_nxt    = op_r;
    tc_nxt    = tc_r;
    bi_nxt    = bi_r;
    sb_nxt    = sb_r;
    done      = 1'b0;
    drive     = 1'b0;
    dur       = 10'd1;
    nb        = {1'b0, bi_r} + 4'd1;

    if (phase_r == owbm_pkg::PH_IDLE && req != owbm_pkg::OP_NONE) begin
      op_nxt = req;
      tc_nxt = 10'd0;
      bi_nxt = 3'd0;
      if (req == owbm_pkg::OP_RESET) begin
        phase_nxt = owbm_pkg::PH_WAITHIGH;
      end else begin
        sb_nxt    = (req == owbm_pkg::OP_WRITE) ? item.tx_byte : 8'd0;
        phase_nxt = owbm_pkg::PH_LOW;
      end
    end

    cur    = sb_nxt[bi_nxt];
    tc_inc = tc_nxt + 10'd1;

    case (phase_nxt)
      owbm_pkg::PH_WAITHIGH: begin
        if (item.line_in) begin
          phase_nxt = owbm_pkg::PH_LOW;
          tc_nxt    = 10'd0;
        end
      end
      owbm_pkg::PH_LOW: begin
        drive = 1'b1;
        if (op_nxt == owbm_pkg::OP_RESET) begin
          dur = owbm_pkg::dur_of(cfg.reset_low_time);
        end else if (op_nxt == owbm_pkg::OP_WRITE) begin
          dur = owbm_pkg::dur_of(cur ? cfg.one_low_time : cfg.zero_low_time);
        end else begin
          dur = owbm_pkg::dur_of(cfg.read_low_time);
        end
        tc_nxt = tc_inc;
        if (tc_inc >= dur) begin
          tc_nxt    = 10'd0;
          phase_nxt = (op_nxt == owbm_pkg::OP_READ) ? owbm_pkg::PH_SAMPLE
                                                    : owbm_pkg::PH_HIGH;
        end
      end
      owbm_pkg::PH_HIGH: begin
        if (op_nxt == owbm_pkg::OP_RESET) begin
          dur = owbm_pkg::dur_of(cfg.reset_release_time);
        end else begin
          dur = owbm_pkg::dur_of(cur ? cfg.one_high_time : cfg.zero_high_time);
        end
        tc_nxt = tc_inc;
        if (tc_inc >= dur) begin
          tc_nxt = 10'd0;
          if (op_nxt == owbm_pkg::OP_RESET || nb >= BIT_LIMIT) begin
            done = 1'b1;
          end else begin
            bi_nxt    = nb[2:0];
            phase_nxt = owbm_pkg::PH_LOW;
          end
        end
      end
      owbm_pkg::PH_SAMPLE: begin
        dur    = owbm_pkg::dur_of(cfg.read_sample_delay);
        tc_nxt = tc_inc;
        if (tc_inc >= dur) begin
          if (item.line_in) begin
            sb_nxt[bi_nxt] = 1'b1;
          end
          tc_nxt    = 10'd0;
          phase_nxt = owbm_pkg::PH_RECOVER;
        end
      end
      owbm_pkg::PH_RECOVER: begin
        dur    = owbm_pkg::dur_of(READ_RECOVERY_TIME);
        tc_nxt = tc_inc;
        if (tc_inc >= dur) begin
          tc_nxt = 10'd0;
          if (nb >= BIT_LIMIT) begin
            done = 1'b1;
          end else begin
            bi_nxt    = nb[2:0];
            phase_nxt = owbm_pkg::PH_LOW;
          end
        end
      end
      default: begin
        phase_nxt = owbm_pkg::PH_IDLE;
      end
    endcase

    res.drive_low = drive;
    res.done_res  = done;
    res.rx_byte   = (done && op_nxt == owbm_pkg::OP_READ) ? sb_nxt : 8'd0;
    if (done) begin
      phase_nxt = owbm_pkg::PH_IDLE;
      op_nxt    = owbm_pkg::OP_NONE;
      tc_nxt    = 10'd0;
      bi_nxt    = 3'd0;
    end
    res.busy_res = (phase_nxt != owbm_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= owbm_pkg::PH_IDLE;
      op_r    <= owbm_pkg::OP_NONE;
      tc_r    <= 10'd0;
      bi_r    <= 3'd0;
      sb_r    <= 8'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      op_r    <= op_nxt;
      tc_r    <= tc_nxt;
      bi_r    <= bi_nxt;
      sb_r    <= sb_nxt;
    end
  end

endmodule

`default_nettype wire

>>> hdl/owbm_checker.sv
`default_nettype none

module owbm_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_drive_low,
  input wire logic       out_busy_res,
  input wire logic       out_done_res,
  input wire logic [7:0] out_rx_byte
);

  a_rst_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res && !out_drive_low)
    else $error("done while busy or driving");

  a_rx_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rx_byte != 8'd0 |-> out_done_res)
    else $error("received byte without done");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive_low)
      && $stable(out_busy_res) && $stable(out_done_res) && $stable(out_rx_byte))
    else $error("stalled result changed");

endmodule

bind one_wire_byte_master_core owbm_checker u_owbm_checker (.*);

`default_nettype wire

>>> dv/tb_one_wire_byte_master_core.sv
`timescale 1ns / 100ps

module tb_one_wire_byte_master_core;

  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD_CYCLES = 60;
  localparam owbm_pkg::res_t QUIET_RES = '0;
  localparam owbm_pkg::res_t WAIT_RES = '{drive_low: 1'b0, busy_res: 1'b1,
                                          done_res: 1'b0, rx_byte: 8'h00};

  typedef struct {
    owbm_pkg::op_t  req;
    logic [7:0]     tx;
    logic           line;
    bit             fixed;
    owbm_pkg::res_t want;
  } script_row_t;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_stall;
  logic [1:0]                    in_req_type;
  logic [7:0]                    in_tx_byte;
  logic                          in_line_in;
  logic                          out_valid;
  logic                          out_stall;
  logic                          out_drive_low;
  logic                          out_busy_res;
  logic                          out_done_res;
  logic [7:0]                    out_rx_byte;
  logic                          cfg_psel;
  logic                          cfg_penable;
  logic                          cfg_pwrite;
  logic [owbm_pkg::ADDR_W-1:0]   cfg_paddr;
  logic [31:0]                   cfg_pwdata;
  logic [31:0]                   cfg_prdata;
  logic                          cfg_pready;

  // bus master model state
  owbm_pkg::phase_t ph = owbm_pkg::PH_IDLE;
  owbm_pkg::op_t    cur_op = owbm_pkg::OP_NONE;
  logic [9:0]       tick_cnt = '0;
  logic [2:0]       bit_idx = '0;
  logic [7:0]       shreg = '0;
  logic [9:0]       timing [owbm_pkg::NUM_REGS];
  int               ops_started = 0;

  owbm_pkg::res_t slot_results_due [$];
  bit             row_fixed;
  owbm_pkg::res_t row_want;
  int             errors = 0;
  int             quiet_cycles = 0;
  bit             calm = 1'b0;
  bit             long_hold = 1'b0;
  script_row_t    script [25];

  one_wire_byte_master_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_req_type   (in_req_type),
    .in_tx_byte    (in_tx_byte),
    .in_line_in    (in_line_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_drive_low (out_drive_low),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_rx_byte   (out_rx_byte),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .cfg_prdata    (cfg_prdata),
    .cfg_pready    (cfg_pready)
  );

  always #10 clk = ~clk;

  function automatic logic [9:0] span(input logic [9:0] v);
    return (v == 10'd0) ? 10'd1 : v;
  endfunction

  function automatic bit byte_complete();
    int nb;
    nb = int'(bit_idx) + 1;
    if (nb >= owbm_pkg::BITS_PER_BYTE) return 1'b1;
    bit_idx = nb[2:0];
    ph = owbm_pkg::PH_LOW;
    tick_cnt = '0;
    return 1'b0;
  endfunction

  task automatic predict_tick(input logic [1:0] req, input logic [7:0] tx, input logic line,
                              output owbm_pkg::res_t r);
    logic [9:0] d;
    bit         fin;
    r = '0;
    fin = 1'b0;
    if (ph == owbm_pkg::PH_IDLE && req != owbm_pkg::OP_NONE) begin
      cur_op = owbm_pkg::op_t'(req);
      tick_cnt = '0;
      bit_idx = '0;
      ops_started++;
      if (cur_op == owbm_pkg::OP_RESET) begin
        ph = owbm_pkg::PH_WAITHIGH;
      end else begin
        shreg = (cur_op == owbm_pkg::OP_WRITE) ? tx : 8'h00;
        ph = owbm_pkg::PH_LOW;
      end
    end
    case (ph)
      owbm_pkg::PH_WAITHIGH: begin
        if (line) begin
          ph = owbm_pkg::PH_LOW;
          tick_cnt = '0;
        end
      end
      owbm_pkg::PH_LOW: begin
        r.drive_low = 1'b1;
        case (cur_op)
          owbm_pkg::OP_RESET: d = timing[owbm_pkg::REG_RESET_LOW];
          owbm_pkg::OP_WRITE: d = shreg[bit_idx] ? timing[owbm_pkg::REG_ONE_LOW]
                                                 : timing[owbm_pkg::REG_ZERO_LOW];
          default:            d = timing[owbm_pkg::REG_READ_LOW];
        endcase
        tick_cnt++;
        if (tick_cnt >= span(d)) begin
          tick_cnt = '0;
          ph = (cur_op == owbm_pkg::OP_READ) ? owbm_pkg::PH_SAMPLE : owbm_pkg::PH_HIGH;
        end
      end
      owbm_pkg::PH_HIGH: begin
        if (cur_op == owbm_pkg::OP_RESET) d = timing[owbm_pkg::REG_RESET_RELEASE];
        else d = shreg[bit_idx] ? timing[owbm_pkg::REG_ONE_HIGH]
                                : timing[owbm_pkg::REG_ZERO_HIGH];
        tick_cnt++;
        if (tick_cnt >= span(d)) begin
          tick_cnt = '0;
          fin = (cur_op == owbm_pkg::OP_RESET) ? 1'b1 : byte_complete();
        end
      end
      owbm_pkg::PH_SAMPLE: begin
        tick_cnt++;
        if (tick_cnt >= span(timing[owbm_pkg::REG_READ_SAMPLE])) begin
          if (line) shreg[bit_idx] = 1'b1;
          tick_cnt = '0;
          ph = owbm_pkg::PH_RECOVER;
        end
      end
      owbm_pkg::PH_RECOVER: begin
        tick_cnt++;
        if (tick_cnt >= span(owbm_pkg::READ_RECOVERY_TIME)) begin
          tick_cnt = '0;
          fin = byte_complete();
        end
      end
      default: ph = owbm_pkg::PH_IDLE;
    endcase
    r.done_res = fin;
    r.rx_byte = (fin && cur_op == owbm_pkg::OP_READ) ? shreg : 8'h00;
    if (fin) begin
      ph = owbm_pkg::PH_IDLE;
      cur_op = owbm_pkg::OP_NONE;
      tick_cnt = '0;
      bit_idx = '0;
    end
    r.busy_res = (ph != owbm_pkg::PH_IDLE);
  endtask

  always @(posedge clk) begin : monitor
    owbm_pkg::res_t pred;
    owbm_pkg::res_t want;
    bit             moved;
    moved = 1'b0;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_tick(in_req_type, in_tx_byte, in_line_in, pred);
        slot_results_due.push_back(row_fixed ? row_want : pred);
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (slot_results_due.size() == 0) begin
          $error("result with nothing expected: drive_low %0b busy_res %0b done_res %0b",
                 out_drive_low, out_busy_res, out_done_res);
          errors++;
        end else begin
          want = slot_results_due.pop_front();
          if (out_drive_low !== want.drive_low) begin
            $error("drive_low expected %0b actual %0b", want.drive_low, out_drive_low);
            errors++;
          end
          if (out_busy_res !== want.busy_res) begin
            $error("busy_res expected %0b actual %0b", want.busy_res, out_busy_res);
            errors++;
          end
          if (out_done_res !== want.done_res) begin
            $error("done_res expected %0b actual %0b", want.done_res, out_done_res);
            errors++;
          end
          if (out_rx_byte !== want.rx_byte) begin
            $error("rx_byte expected %02h actual %02h", want.rx_byte, out_rx_byte);
            errors++;
          end
        end
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        long_hold = 1'b0;
        out_stall = 1'b1;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        out_stall = 1'b0;
      end else if (!calm && $urandom_range(0, 19) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 15)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  task automatic drive_request(input owbm_pkg::op_t req, input logic [7:0] tx,
                               input logic line, input bit fixed,
                               input owbm_pkg::res_t want);
    int gap;
    if (!calm && $urandom_range(0, 19) == 0) begin
      in_valid = 1'b0;
      gap = $urandom_range(1, 15);
      repeat (gap) @(negedge clk);
    end
    in_req_type = req;
    in_tx_byte = tx;
    in_line_in = line;
    row_fixed = fixed;
    row_want = want;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic write_timing(input owbm_pkg::reg_idx_t idx, input logic [9:0] val);
    in_valid = 1'b0;
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = {22'd0, val};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    timing[idx] = val;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
  endtask

  task automatic load_timing(input owbm_pkg::cfg_t c);
    write_timing(owbm_pkg::REG_RESET_LOW, c.reset_low_time);
    write_timing(owbm_pkg::REG_RESET_RELEASE, c.reset_release_time);
    write_timing(owbm_pkg::REG_ONE_LOW, c.one_low_time);
    write_timing(owbm_pkg::REG_ONE_HIGH, c.one_high_time);
    write_timing(owbm_pkg::REG_ZERO_LOW, c.zero_low_time);
    write_timing(owbm_pkg::REG_ZERO_HIGH, c.zero_high_time);
    write_timing(owbm_pkg::REG_READ_LOW, c.read_low_time);
    write_timing(owbm_pkg::REG_READ_SAMPLE, c.read_sample_delay);
  endtask

  function automatic owbm_pkg::cfg_t random_timing(input int hi);
    owbm_pkg::cfg_t c;
    c.reset_low_time = 10'($urandom_range(0, hi));
    c.reset_release_time = 10'($urandom_range(0, hi));
    c.one_low_time = 10'($urandom_range(0, hi));
    c.one_high_time = 10'($urandom_range(0, hi));
    c.zero_low_time = 10'($urandom_range(0, hi));
    c.zero_high_time = 10'($urandom_range(0, hi));
    c.read_low_time = 10'($urandom_range(0, hi));
    c.read_sample_delay = 10'($urandom_range(0, hi));
    return c;
  endfunction

  // finish the running operation, then wait for every result
  task automatic settle_bus();
    logic line;
    while (ph != owbm_pkg::PH_IDLE) begin
      line = (ph == owbm_pkg::PH_WAITHIGH) ? 1'b1 : 1'($urandom);
      drive_request(owbm_pkg::OP_NONE, 8'($urandom), line, 1'b0, QUIET_RES);
    end
    in_valid = 1'b0;
    while (slot_results_due.size() != 0) @(negedge clk);
  endtask

  task automatic run_traffic(input int n_ops);
    int            goal;
    owbm_pkg::op_t req;
    logic [7:0]    tx;
    logic          line;
    goal = ops_started + n_ops;
    while (ops_started < goal) begin
      tx = 8'($urandom);
      line = ($urandom_range(0, 3) != 0);
      if (ph == owbm_pkg::PH_IDLE)
        req = ($urandom_range(0, 3) == 0) ? owbm_pkg::OP_NONE
                                          : owbm_pkg::op_t'($urandom_range(1, 2));
      else
        req = ($urandom_range(0, 15) == 0) ? owbm_pkg::op_t'($urandom_range(1, 3))
                                           : owbm_pkg::OP_NONE;
      drive_request(req, tx, line, 1'b0, QUIET_RES);
    end
    settle_bus();
  endtask

  initial begin
    timing = '{owbm_pkg::RESET_LOW_DEF, owbm_pkg::RESET_RELEASE_DEF,
               owbm_pkg::ONE_LOW_DEF, owbm_pkg::ONE_HIGH_DEF,
               owbm_pkg::ZERO_LOW_DEF, owbm_pkg::ZERO_HIGH_DEF,
               owbm_pkg::READ_LOW_DEF, owbm_pkg::READ_SAMPLE_DEF};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = owbm_pkg::OP_NONE;
    in_tx_byte = 8'h00;
    in_line_in = 1'b0;
    row_fixed = 1'b0;
    row_want = QUIET_RES;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;

    script[0]  = '{owbm_pkg::OP_NONE,  8'h00, 1'b0, 1'b1, QUIET_RES};
    script[1]  = '{owbm_pkg::OP_RESET, 8'h00, 1'b0, 1'b1, WAIT_RES};
    script[2]  = '{owbm_pkg::OP_READ,  8'hFF, 1'b0, 1'b1, WAIT_RES};
    script[3]  = '{owbm_pkg::OP_NONE,  8'h00, 1'b0, 1'b1, WAIT_RES};
    script[4]  = '{owbm_pkg::OP_NONE,  8'h00, 1'b1, 1'b1, WAIT_RES};
    script[5]  = '{owbm_pkg::OP_NONE,  8'h00, 1'b0, 1'b0, QUIET_RES};
    script[6]  = '{owbm_pkg::OP_NONE,  8'h00, 1'b1, 1'b0, QUIET_RES};
    script[7]  = '{owbm_pkg::OP_WRITE, 8'hFF, 1'b1, 1'b0, QUIET_RES};
    script[8]  = '{owbm_pkg::OP_WRITE, 8'h00, 1'b0, 1'b0, QUIET_RES};
    script[9]  = '{owbm_pkg::OP_READ,  8'h00, 1'b1, 1'b0, QUIET_RES};
    for (int i = 10; i < 22; i++)
      script[i] = '{owbm_pkg::OP_NONE, 8'h00, 1'(i % 2), 1'b0, QUIET_RES};
    script[22] = '{owbm_pkg::OP_RESET, 8'hFF, 1'b1, 1'b0, QUIET_RES};
    script[23] = '{owbm_pkg::OP_READ,  8'hA5, 1'b0, 1'b0, QUIET_RES};
    script[24] = '{owbm_pkg::OP_WRITE, 8'h00, 1'b1, 1'b0, QUIET_RES};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // zero in every timing register acts as a single tick
    load_timing('0);
    foreach (script[i])
      drive_request(script[i].req, script[i].tx, script[i].line, script[i].fixed,
                    script[i].want);
    settle_bus();

    for (int p = 0; p < 3; p++) begin
      load_timing(random_timing(3));
      if (p == 0) long_hold = 1'b1;
      run_traffic(2);
    end

    calm = 1'b1;
    load_timing(random_timing(3));
    run_traffic(2);

    repeat (10) @(negedge clk);
    if (errors == 0 && slot_results_due.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
